### rtl/core/pse_pkg.sv
// shared types, codes and defaults for the postfix stack evaluator
package pse_pkg;

   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam int VALUE_WIDTH_DEFAULT = 32;
   // token queue between front and back, power of two
   localparam int QUEUE_DEPTH = 2;

   localparam logic [3:0] OP_VALUE = 4'd0;
   localparam logic [3:0] OP_OR    = 4'd1;
   localparam logic [3:0] OP_XOR   = 4'd2;
   localparam logic [3:0] OP_AND   = 4'd3;
   localparam logic [3:0] OP_EQUAL = 4'd4;
   localparam logic [3:0] OP_ADD   = 4'd5;
   localparam logic [3:0] OP_SUB   = 4'd6;
   localparam logic [3:0] OP_MUL   = 4'd7;
   localparam logic [3:0] OP_DIV   = 4'd8;
   localparam logic [3:0] OP_MOD   = 4'd9;
   localparam logic [3:0] OP_NEG   = 4'd10;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_OVERFLOW = 3'd1,
      ST_UNDERFLOW= 3'd2,
      ST_EMPTY    = 3'd3,
      ST_LEFTOVER = 3'd4,
      ST_BAD      = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      KIND_PUSH = 2'd0,
      KIND_NEG  = 2'd1,
      KIND_BIN  = 2'd2,
      KIND_BAD  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [3:0]         op;
      logic signed [31:0] operand;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      status_type         status;
   } rsp_type;

   typedef struct packed {
      kind_type           kind;
      logic [3:0]         op;
      logic signed [31:0] operand;
      logic               last;
   } tok_type;

   typedef struct packed {
      logic    valid;
      tok_type tok;
   } head_type;

endpackage

### rtl/core/pse_ram.sv
// generic single write port, single read port ram with registered read
module pse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/pse_div.sv
// iterative signed divider, one quotient bit per cycle, truncating
module pse_div #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CntW = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic             neg_q_ff, neg_q_in;
   logic             neg_r_ff, neg_r_in;
   logic [WIDTH:0]   rem_sh;
   logic [WIDTH:0]   diff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      rem_sh   = {rem_ff, quo_ff[WIDTH-1]};
      diff     = rem_sh - {1'b0, dsr_ff};
      if (start) begin
         busy_in  = 1'b1;
         count_in = CntW'(WIDTH);
         rem_in   = '0;
         // magnitudes; the most negative value maps onto itself as unsigned
         quo_in   = dividend[WIDTH-1] ? ('0 - dividend) : dividend;
         dsr_in   = divisor[WIDTH-1] ? ('0 - divisor) : divisor;
         neg_q_in = dividend[WIDTH-1] ^ divisor[WIDTH-1];
         neg_r_in = dividend[WIDTH-1];
      end else if (busy_ff) begin
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         count_in = count_ff - CntW'(1);
         if (count_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dsr_ff   <= dsr_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   assign done      = done_ff;
   assign quotient  = neg_q_ff ? ('0 - quo_ff) : quo_ff;
   assign remainder = neg_r_ff ? ('0 - rem_ff) : rem_ff;

endmodule

### rtl/core/pse_front.sv
// token intake: classifies each token and queues it for the execute side
module pse_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  pse_pkg::req_type  req_data,
   output pse_pkg::head_type head,
   input  logic              head_pop
);

   localparam int PtrW = (pse_pkg::QUEUE_DEPTH > 1) ? $clog2(pse_pkg::QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(pse_pkg::QUEUE_DEPTH + 1);

   pse_pkg::tok_type q_ff [pse_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   pse_pkg::tok_type tok;
   logic             wr_en;
   logic             rd_en;

   always_comb begin
      tok.op      = req_data.op;
      tok.operand = req_data.operand;
      tok.last    = req_data.last;
      case (req_data.op)
         pse_pkg::OP_VALUE: tok.kind = pse_pkg::KIND_PUSH;
         pse_pkg::OP_NEG:   tok.kind = pse_pkg::KIND_NEG;
         pse_pkg::OP_OR,
         pse_pkg::OP_XOR,
         pse_pkg::OP_AND,
         pse_pkg::OP_EQUAL,
         pse_pkg::OP_ADD,
         pse_pkg::OP_SUB,
         pse_pkg::OP_MUL,
         pse_pkg::OP_DIV,
         pse_pkg::OP_MOD:   tok.kind = pse_pkg::KIND_BIN;
         default:           tok.kind = pse_pkg::KIND_BAD;
      endcase
   end

   assign full  = (count_ff == CntW'(pse_pkg::QUEUE_DEPTH));
   assign wr_en = push && !full;
   assign rd_en = head_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = wr_ptr_ff + PtrW'(1);
      end
      if (rd_en) begin
         rd_ptr_in = rd_ptr_ff + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CntW'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_ff[wr_ptr_ff] <= tok;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.tok   = q_ff[rd_ptr_ff];

endmodule

### rtl/core/pse_back.sv
// execute side: value stack, alu, multiplier halves, divider and result register
module pse_back #(
   parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = pse_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  pse_pkg::head_type head,
   output logic              head_pop,
   output logic              rsp_valid,
   input  logic              rsp_pop,
   output pse_pkg::rsp_type  rsp_data
);

   localparam int DepthW = $clog2(STACK_DEPTH + 1);
   localparam int AddrW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int LoW    = (VALUE_WIDTH + 1) / 2;
   localparam int HiW    = VALUE_WIDTH - LoW;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_MUL  = 5'b00100,
      S_DIV  = 5'b01000,
      S_EMIT = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [DepthW-1:0]    depth_ff, depth_in;
   pse_pkg::status_type  err_ff, err_in;
   logic [VALUE_WIDTH-1:0] tos_ff, tos_in;
   logic [3:0]           op_ff, op_in;
   logic                 last_ff, last_in;
   logic [VALUE_WIDTH-1:0] ll_ff, ll_in;
   logic [HiW-1:0]       cross_ff, cross_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   pse_pkg::rsp_type     rsp_ff, rsp_in;

   logic                   ram_wr_en;
   logic [AddrW-1:0]       ram_wr_addr;
   logic [VALUE_WIDTH-1:0] ram_wr_data;
   logic                   ram_rd_en;
   logic [AddrW-1:0]       ram_rd_addr;
   logic [VALUE_WIDTH-1:0] ram_rd_data;

   logic                   div_start;
   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_quo;
   logic [VALUE_WIDTH-1:0] div_rem;

   logic [DepthW-1:0]      depth_m1;
   logic [DepthW-1:0]      depth_m2;
   logic [VALUE_WIDTH-1:0] b_val;
   logic [LoW-1:0]         a_lo, b_lo;
   logic [HiW-1:0]         a_hi, b_hi;
   logic                   slot_free;
   state_type              after_tok;

   // entries below the top live in the ram, the top entry lives in tos_ff
   pse_ram #(
      .WIDTH(VALUE_WIDTH),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   pse_div #(
      .WIDTH(VALUE_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ram_rd_data),
      .divisor  (tos_ff),
      .done     (div_done),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   assign depth_m1    = depth_ff - DepthW'(1);
   assign depth_m2    = depth_ff - DepthW'(2);
   assign b_val       = ram_rd_data;
   assign a_lo        = tos_ff[LoW-1:0];
   assign a_hi        = tos_ff[VALUE_WIDTH-1:LoW];
   assign b_lo        = b_val[LoW-1:0];
   assign b_hi        = b_val[VALUE_WIDTH-1:LoW];
   assign slot_free   = !rsp_valid_ff || rsp_pop;
   assign ram_wr_addr = depth_m1[AddrW-1:0];
   assign ram_wr_data = tos_ff;
   assign ram_rd_addr = depth_m2[AddrW-1:0];

   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      err_in       = err_ff;
      tos_in       = tos_ff;
      op_in        = op_ff;
      last_in      = last_ff;
      ll_in        = ll_ff;
      cross_in     = cross_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      head_pop     = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      div_start    = 1'b0;
      after_tok    = last_ff ? S_EMIT : S_IDLE;

      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               head_pop = 1'b1;
               op_in    = head.tok.op;
               last_in  = head.tok.last;
               state_in = head.tok.last ? S_EMIT : S_IDLE;
               // after a fault the rest of the expression is dropped
               if (err_ff == pse_pkg::ST_OK) begin
                  case (head.tok.kind)
                     pse_pkg::KIND_PUSH: begin
                        if (depth_ff == DepthW'(STACK_DEPTH)) begin
                           err_in = pse_pkg::ST_OVERFLOW;
                        end else begin
                           ram_wr_en = (depth_ff != '0);
                           tos_in    = VALUE_WIDTH'(head.tok.operand);
                           depth_in  = depth_ff + DepthW'(1);
                        end
                     end
                     pse_pkg::KIND_NEG: begin
                        if (depth_ff == '0) begin
                           err_in = pse_pkg::ST_UNDERFLOW;
                        end else begin
                           tos_in = '0 - tos_ff;
                        end
                     end
                     pse_pkg::KIND_BIN: begin
                        if (depth_ff < DepthW'(2)) begin
                           err_in = pse_pkg::ST_UNDERFLOW;
                        end else if ((head.tok.op == pse_pkg::OP_DIV ||
                                      head.tok.op == pse_pkg::OP_MOD) && tos_ff == '0) begin
                           err_in = pse_pkg::ST_BAD;
                        end else begin
                           ram_rd_en = 1'b1;
                           state_in  = S_EXEC;
                        end
                     end
                     default: begin
                        err_in = pse_pkg::ST_BAD;
                     end
                  endcase
               end
            end
         end

         S_EXEC: begin
            state_in = after_tok;
            depth_in = depth_m1;
            case (op_ff)
               pse_pkg::OP_OR:    tos_in = b_val | tos_ff;
               pse_pkg::OP_XOR:   tos_in = b_val ^ tos_ff;
               pse_pkg::OP_AND:   tos_in = b_val & tos_ff;
               pse_pkg::OP_EQUAL: tos_in = (b_val == tos_ff) ? VALUE_WIDTH'(1) : '0;
               pse_pkg::OP_ADD:   tos_in = b_val + tos_ff;
               pse_pkg::OP_SUB:   tos_in = b_val - tos_ff;
               pse_pkg::OP_MUL: begin
                  // low half product plus the cross terms that land below the wrap
                  ll_in    = {{HiW{1'b0}}, a_lo} * {{HiW{1'b0}}, b_lo};
                  cross_in = a_hi * b_lo[HiW-1:0] + a_lo[HiW-1:0] * b_hi;
                  depth_in = depth_ff;
                  state_in = S_MUL;
               end
               default: begin
                  div_start = 1'b1;
                  depth_in  = depth_ff;
                  state_in  = S_DIV;
               end
            endcase
         end

         S_MUL: begin
            tos_in   = ll_ff + {cross_ff, {LoW{1'b0}}};
            depth_in = depth_m1;
            state_in = after_tok;
         end

         S_DIV: begin
            if (div_done) begin
               tos_in   = (op_ff == pse_pkg::OP_DIV) ? div_quo : div_rem;
               depth_in = depth_m1;
               state_in = after_tok;
            end
         end

         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in.result = '0;
               if (err_ff != pse_pkg::ST_OK) begin
                  rsp_in.status = err_ff;
               end else if (depth_ff == '0) begin
                  rsp_in.status = pse_pkg::ST_EMPTY;
               end else if (depth_ff > DepthW'(1)) begin
                  rsp_in.status = pse_pkg::ST_LEFTOVER;
               end else begin
                  rsp_in.status = pse_pkg::ST_OK;
                  rsp_in.result = 32'(tos_ff);
               end
               depth_in = '0;
               err_in   = pse_pkg::ST_OK;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         err_ff       <= pse_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff   <= tos_in;
      op_ff    <= op_in;
      last_ff  <= last_in;
      ll_ff    <= ll_in;
      cross_ff <= cross_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/core/postfix_stack_evaluator.sv
// top level of the postfix stack evaluator
//
//   channel   ports                      transfer when
//   tokens    push, full, req_data       push && !full
//   results   empty, pop, rsp_data       pop && !empty
//
// work per token in the execute side: a value, negate, bad or dropped token is handled
// directly; or/xor/and/equal/add/sub add a stack ram read; mul adds a step to sum the
// product halves; div/mod wait on the divider, which gives one quotient bit per cycle.
// a token marked last then goes on to write the result register.
// reset clears depth, sticky error and both queues; the stack ram is not cleared.
// a full result register stalls the execute side only on a last token.
module postfix_stack_evaluator #(
   parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = pse_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  pse_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output pse_pkg::rsp_type rsp_data
);

   pse_pkg::head_type head;
   logic              head_pop;
   logic              rsp_valid;

   pse_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .req_data(req_data),
      .head    (head),
      .head_pop(head_pop)
   );

   pse_back #(
      .STACK_DEPTH(STACK_DEPTH),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .head_pop (head_pop),
      .rsp_valid(rsp_valid),
      .rsp_pop  (pop),
      .rsp_data (rsp_data)
   );

   assign empty = !rsp_valid;

endmodule

### tb/testbench.sv
// self-checking testbench for the postfix stack evaluator
module testbench;
   import pse_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int TAIL_CYCLES   = 64;
   localparam int HOLD_CYCLES   = 250;
   localparam int RANDOM_TOKENS = 650;
   localparam logic [3:0] OP_BAD_LOW  = 4'd11;
   localparam logic [3:0] OP_BAD_HIGH = 4'd15;
   localparam logic [31:0] VAL_MIN = 32'h8000_0000;
   localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;
   localparam logic [31:0] VAL_M1  = 32'hffff_ffff;

   typedef struct {
      req_type tok;
      bit      drain_first;
   } token_slot;

   logic    clock;
   logic    reset    = 1'b1;
   logic    push     = 1'b0;
   logic    pop      = 1'b0;
   req_type req_data = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_data;

   postfix_stack_evaluator u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // evaluator state mirrored on the bench side
   logic [31:0] eval_stack [STACK_DEPTH_DEFAULT];
   int          eval_depth = 0;
   status_type  eval_error = ST_OK;

   token_slot token_queue [$];
   rsp_type   due_results [$];

   int  cycle_count    = 0;
   int  mismatch_count = 0;
   int  sent_count     = 0;
   int  result_count   = 0;
   int  full_cycles    = 0;
   int  status_seen [8];
   int  hold_at        = 32'h7fff_ffff;
   bit  tok_taken      = 1'b0;

   // sender and receiver pacing
   int  burst_left   = 1;
   int  gap_left     = 0;
   bit  drv_next     = 1'b0;
   int  hold_left    = 0;
   bit  hold_done    = 1'b0;
   int  pattern_left = 0;
   int  pattern_mode = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] pick_operand();
      int sel;
      sel = $urandom_range(0, 7);
      case (sel)
         0: return VAL_MIN;
         1: return VAL_MAX;
         2: return VAL_M1;
         3: return 32'd0;
         4, 5: return $urandom_range(0, 32) - 16;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_tok(input logic [3:0] op, input logic [31:0] operand, input bit last);
      token_slot s;
      s.tok.op      = op;
      s.tok.operand = operand;
      s.tok.last    = last;
      s.drain_first = 1'b0;
      token_queue.push_back(s);
   endtask

   // well-formed expression; push_first piles all values up before reducing
   task automatic add_expr(input int n_values, input bit push_first);
      req_type seq [$];
      req_type t;
      int      d;
      int      p;
      d = 0;
      p = n_values;
      while (p > 0 || d > 1) begin
         t.operand = pick_operand();
         t.last    = 1'b0;
         if (p > 0 && (d < 2 || push_first || $urandom_range(0, 2) == 0)) begin
            t.op = OP_VALUE;
            d++;
            p--;
         end else if ($urandom_range(0, 7) == 0) begin
            t.op = OP_NEG;
         end else begin
            t.op = 4'($urandom_range(OP_OR, OP_MOD));
            d--;
         end
         seq.push_back(t);
      end
      seq[seq.size() - 1].last = 1'b1;
      foreach (seq[i]) add_tok(seq[i].op, seq[i].operand, seq[i].last);
   endtask

   // random codes, invalid ones included, with stray last marks
   task automatic add_noise(input int n);
      for (int i = 0; i < n; i++)
         add_tok(4'($urandom_range(0, OP_BAD_HIGH)), pick_operand(),
                 (i == n - 1) || ($urandom_range(0, 4) == 0));
   endtask

   task automatic eval_token(input req_type t);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] r;
      longint      sa;
      longint      sb;
      longint      q;
      rsp_type     e;
      if (eval_error == ST_OK) begin
         if (t.op == OP_VALUE) begin
            if (eval_depth >= STACK_DEPTH_DEFAULT) begin
               eval_error = ST_OVERFLOW;
            end else begin
               eval_stack[eval_depth] = t.operand;
               eval_depth++;
            end
         end else if (t.op == OP_NEG) begin
            if (eval_depth < 1) eval_error = ST_UNDERFLOW;
            else eval_stack[eval_depth - 1] = -eval_stack[eval_depth - 1];
         end else if (t.op > OP_NEG) begin
            eval_error = ST_BAD;
         end else if (eval_depth < 2) begin
            eval_error = ST_UNDERFLOW;
         end else begin
            a  = eval_stack[eval_depth - 1];
            b  = eval_stack[eval_depth - 2];
            sa = $signed(a);
            sb = $signed(b);
            r  = '0;
            case (t.op)
               OP_OR:    r = b | a;
               OP_XOR:   r = b ^ a;
               OP_AND:   r = b & a;
               OP_EQUAL: r = (b == a) ? 32'd1 : 32'd0;
               OP_ADD:   r = b + a;
               OP_SUB:   r = b - a;
               OP_MUL:   r = b * a;
               // 64-bit signed math: truncating quotient, min / -1 wraps on the slice
               OP_DIV: begin
                  q = (a == 0) ? 0 : sb / sa;
                  r = q[31:0];
               end
               OP_MOD: begin
                  q = (a == 0) ? 0 : sb % sa;
                  r = q[31:0];
               end
               default: r = '0;
            endcase
            if ((t.op == OP_DIV || t.op == OP_MOD) && a == 0) begin
               eval_error = ST_BAD;
            end else begin
               eval_depth--;
               eval_stack[eval_depth - 1] = r;
            end
         end
      end
      if (t.last) begin
         e.result = '0;
         if (eval_error != ST_OK) begin
            e.status = eval_error;
         end else if (eval_depth == 0) begin
            e.status = ST_EMPTY;
         end else if (eval_depth > 1) begin
            e.status = ST_LEFTOVER;
         end else begin
            e.status = ST_OK;
            e.result = eval_stack[0];
         end
         due_results.push_back(e);
         eval_depth = 0;
         eval_error = ST_OK;
      end
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $time, due_results.size());
         $display("[FAIL] regression broken");
         $finish;
      end
      if (reset) begin
         tok_taken = 1'b0;
      end else begin
         tok_taken = push && !full;
         if (push && full) full_cycles++;
         if (tok_taken) begin
            eval_token(req_data);
            sent_count++;
         end
         if (pop && !empty) begin
            result_count++;
            status_seen[int'(rsp_data.status)]++;
            if (due_results.size() == 0) begin
               $display("%0t unexpected result: expected none actual %0d status %0d",
                        $time, rsp_data.result, rsp_data.status);
               mismatch_count++;
            end else begin
               if (rsp_data.result !== due_results[0].result) begin
                  $display("%0t result mismatch: expected %0d actual %0d",
                           $time, due_results[0].result, rsp_data.result);
                  mismatch_count++;
               end
               if (rsp_data.status !== due_results[0].status) begin
                  $display("%0t status mismatch: expected %0d actual %0d",
                           $time, due_results[0].status, rsp_data.status);
                  mismatch_count++;
               end
               void'(due_results.pop_front());
            end
         end
      end
   end

   // token sender, bursts and gaps
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!(push && !tok_taken)) begin
         drv_next = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (token_queue.size() > 0 &&
                      !(token_queue[0].drain_first && due_results.size() > 0)) begin
            req_data <= token_queue[0].tok;
            void'(token_queue.pop_front());
            drv_next = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               if ($urandom_range(0, 5) == 0) begin
                  burst_left = 60;
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end
         end
         push <= drv_next;
      end
   end

   // result receiver with its own stall pattern and one long hold
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (!hold_done && sent_count >= hold_at) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               pattern_mode = $urandom_range(0, 3);
               pattern_left = $urandom_range(8, 64);
            end
            pattern_left--;
            case (pattern_mode)
               0: pop <= 1'b1;
               1: pop <= 1'($urandom_range(0, 1));
               2: pop <= ($urandom_range(0, 3) == 0);
               default: pop <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin
      int  base;
      int  drain_idx;
      int  deep_count;
      bit  drain_placed;
      deep_count   = 0;
      drain_placed = 1'b0;

      // wraparound on add and mul, negate of the result
      add_tok(OP_VALUE, VAL_MAX, 1'b0);
      add_tok(OP_VALUE, 32'd1, 1'b0);
      add_tok(OP_ADD, '0, 1'b0);
      add_tok(OP_VALUE, 32'd3, 1'b0);
      add_tok(OP_MUL, '0, 1'b0);
      add_tok(OP_NEG, '0, 1'b1);
      // min / -1 wraps, negative dividend remainder, xor
      add_tok(OP_VALUE, VAL_MIN, 1'b0);
      add_tok(OP_VALUE, VAL_M1, 1'b0);
      add_tok(OP_DIV, '0, 1'b0);
      add_tok(OP_VALUE, -32'sd7, 1'b0);
      add_tok(OP_VALUE, 32'd2, 1'b0);
      add_tok(OP_MOD, '0, 1'b0);
      add_tok(OP_XOR, '0, 1'b1);
      // min mod -1 is zero, equality, subtract
      add_tok(OP_VALUE, VAL_MIN, 1'b0);
      add_tok(OP_VALUE, VAL_M1, 1'b0);
      add_tok(OP_MOD, '0, 1'b0);
      add_tok(OP_VALUE, 32'd0, 1'b0);
      add_tok(OP_EQUAL, '0, 1'b0);
      add_tok(OP_VALUE, 32'd7, 1'b0);
      add_tok(OP_SUB, '0, 1'b1);
      // divide by zero, negate on empty stack, invalid code, underflow on or
      add_tok(OP_VALUE, 32'd5, 1'b0);
      add_tok(OP_VALUE, 32'd0, 1'b0);
      add_tok(OP_DIV, '0, 1'b1);
      add_tok(OP_NEG, '0, 1'b1);
      add_tok(OP_BAD_HIGH, VAL_M1, 1'b1);
      add_tok(OP_VALUE, VAL_M1, 1'b0);
      add_tok(OP_OR, '0, 1'b0);
      add_tok(OP_VALUE, 32'd1, 1'b0);
      add_tok(OP_VALUE, 32'd2, 1'b1);

      base = token_queue.size();
      while (token_queue.size() < base + RANDOM_TOKENS) begin
         if (hold_at == 32'h7fff_ffff && token_queue.size() >= base + 300) begin
            // short expressions back to back while the receiver holds off
            hold_at = token_queue.size();
            for (int i = 0; i < 24; i++) add_tok(OP_VALUE, pick_operand(), 1'b1);
         end else if (!drain_placed && token_queue.size() >= base + 450) begin
            drain_idx = token_queue.size();
            add_expr($urandom_range(1, 8), 1'b0);
            token_queue[drain_idx].drain_first = 1'b1;
            drain_placed = 1'b1;
         end else begin
            case ($urandom_range(0, 19))
               0: begin
                  if (deep_count < 2) begin
                     add_expr($urandom_range(58, 66), 1'b1);
                     deep_count++;
                  end
               end
               1, 2: add_noise($urandom_range(1, 6));
               3: add_tok(4'($urandom_range(OP_BAD_LOW, OP_BAD_HIGH)), pick_operand(), 1'b1);
               default: add_expr($urandom_range(1, 8), 1'b0);
            endcase
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (token_queue.size() != 0 || push) @(negedge clock);
      while (due_results.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("sent %0d tokens, checked %0d results, input stalled on full %0d cycles",
               sent_count, result_count, full_cycles);
      $display("status mix: ok %0d overflow %0d underflow %0d leftover %0d bad %0d",
               status_seen[ST_OK], status_seen[ST_OVERFLOW], status_seen[ST_UNDERFLOW],
               status_seen[ST_LEFTOVER], status_seen[ST_BAD]);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### postfix_stack_evaluator.f
rtl/core/pse_pkg.sv
rtl/core/pse_ram.sv
rtl/core/pse_div.sv
rtl/core/pse_front.sv
rtl/core/pse_back.sv
rtl/core/postfix_stack_evaluator.sv
tb/testbench.sv
